// File: hdl/rce_pkg.sv
package rce_pkg;

    localparam int MAX_LOG_TOTAL = 21;
    localparam int PENDING_BITS  = 16;

    localparam logic [31:0] TOP_BIT      = 32'h8000_0000;
    localparam logic [31:0] BOTTOM_LEVEL = 32'h0080_0000;
    localparam logic [31:0] FF_LEVEL     = 32'h7F80_0000;
    localparam logic [23:0] FINISH_BYTES = 24'd5;
    localparam logic [4:0]  LOG_LIMIT    = 5'(MAX_LOG_TOTAL);
    localparam logic [1:0]  MAX_STEPS    = 2'd3;
    localparam logic [7:0]  RUN_NO_CARRY = 8'hFF;
    localparam logic [7:0]  RUN_CARRY    = 8'h00;

    localparam logic [15:0] PENDING_LIMIT = (PENDING_BITS >= 16) ? 16'hFFFF :
                                            16'((32'd1 << PENDING_BITS) - 32'd1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_MODE   = 1'd1;

    typedef struct packed {
        logic        command;
        logic [20:0] cum_freq;
        logic [21:0] sym_freq;
        logic [4:0]  log_total;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [7:0]  run_byte;
        logic [15:0] run_count;
        logic        overflow;
        logic        last;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_NORM,
        OP_SHIFT,
        OP_MUL_T,
        OP_MUL_F,
        OP_FIN_CNT,
        OP_FIN_FLUSH,
        OP_FIN_CODE,
        OP_FIN_CB2,
        OP_FIN_CB1,
        OP_FIN_CB0,
        OP_DONE
    } t_op;

    typedef struct packed {
        logic need_norm;
        logic is_finish;
        logic out_free;
    } t_dp_status;

endpackage

// File: hdl/rce_ctrl.sv
module rce_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  rce_pkg::t_dp_status i_status,
    output rce_pkg::t_op        o_op,
    output logic                o_in_stall
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM,
        S_MUL_T,
        S_MUL_F,
        S_FLUSH,
        S_CODE,
        S_CB2,
        S_CB1,
        S_CB0,
        S_DONE
    } t_state;

    t_state       r_state, n_state;
    logic [1:0]   r_cnt, n_cnt;
    rce_pkg::t_op w_op;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        w_op    = rce_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_op    = rce_pkg::OP_LOAD;
                    n_state = S_NORM;
                    n_cnt   = 2'd0;
                end
            end
            S_NORM: begin
                if (i_status.need_norm && (r_cnt != rce_pkg::MAX_STEPS)) begin
                    if (i_status.out_free) begin
                        w_op  = rce_pkg::OP_NORM;
                        n_cnt = r_cnt + 2'd1;
                    end
                end else if (i_status.is_finish) begin
                    w_op    = rce_pkg::OP_FIN_CNT;
                    n_state = S_FLUSH;
                end else begin
                    w_op    = rce_pkg::OP_SHIFT;
                    n_state = S_MUL_T;
                end
            end
            S_MUL_T: begin
                w_op    = rce_pkg::OP_MUL_T;
                n_state = S_MUL_F;
            end
            S_MUL_F: begin
                w_op    = rce_pkg::OP_MUL_F;
                n_state = S_DONE;
            end
            S_FLUSH: begin
                if (i_status.out_free) begin
                    w_op    = rce_pkg::OP_FIN_FLUSH;
                    n_state = S_CODE;
                end
            end
            S_CODE: begin
                if (i_status.out_free) begin
                    w_op    = rce_pkg::OP_FIN_CODE;
                    n_state = S_CB2;
                end
            end
            S_CB2: begin
                if (i_status.out_free) begin
                    w_op    = rce_pkg::OP_FIN_CB2;
                    n_state = S_CB1;
                end
            end
            S_CB1: begin
                if (i_status.out_free) begin
                    w_op    = rce_pkg::OP_FIN_CB1;
                    n_state = S_CB0;
                end
            end
            S_CB0: begin
                if (i_status.out_free) begin
                    w_op    = rce_pkg::OP_FIN_CB0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    w_op    = rce_pkg::OP_DONE;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_op       = w_op;
    assign o_in_stall = (r_state != S_IDLE);

endmodule

// File: hdl/rce_datapath.sv
module rce_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rce_pkg::t_op                        i_op,
    input  rce_pkg::t_in_item                   i_in_data,
    input  logic                                i_cfg_we,
    input  logic [rce_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rce_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output rce_pkg::t_out_item                  o_out_data,
    output rce_pkg::t_dp_status                 o_status
);

    logic               r_cmd, n_cmd;
    logic [20:0]        r_cum, n_cum;
    logic [21:0]        r_sf, n_sf;
    logic [4:0]         r_lg, n_lg;
    logic [31:0]        r_low, n_low;
    logic [31:0]        r_width, n_width;
    logic [7:0]         r_held, n_held;
    logic [15:0]        r_pend, n_pend;
    logic [23:0]        r_bc, n_bc;
    logic               r_ovf, n_ovf;
    logic [31:0]        r_r, n_r;
    logic [31:0]        r_t, n_t;
    logic               r_use_sub, n_use_sub;
    logic [7:0]         r_fin, n_fin;
    logic [7:0]         r_hdr, n_hdr;
    logic               r_fast, n_fast;
    logic               r_stg_valid, n_stg_valid;
    rce_pkg::t_out_item r_stg, n_stg;
    logic               r_out_valid, n_out_valid;
    rce_pkg::t_out_item r_out, n_out;

    logic [21:0]        w_mul_b;
    logic [53:0]        w_mul;
    logic [22:0]        w_sum;
    logic               w_below;
    logic [9:0]         w_fin;
    logic               w_carry;
    logic               w_out_free;
    logic               w_new_valid;
    rce_pkg::t_out_item w_new;
    logic               w_push;

    assign w_mul_b = (i_op == rce_pkg::OP_MUL_F) ? r_sf : {1'b0, r_cum};
    assign w_mul   = r_r * w_mul_b;
    assign w_sum   = {2'b00, r_cum} + {1'b0, r_sf};
    assign w_below = r_low[22:0] < r_bc[23:1];
    assign w_fin   = {1'b0, r_low[31:23]} + {9'd0, !w_below};
    assign w_carry = |w_fin[9:8];
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        w_new_valid = 1'b0;
        w_new       = '0;
        w_new.overflow = r_ovf;
        unique case (i_op)
            rce_pkg::OP_NORM: begin
                if (r_low < rce_pkg::FF_LEVEL) begin
                    w_new_valid     = 1'b1;
                    w_new.out_byte  = r_held;
                    w_new.run_byte  = rce_pkg::RUN_NO_CARRY;
                    w_new.run_count = r_pend;
                end else if (r_low[31]) begin
                    w_new_valid     = 1'b1;
                    w_new.out_byte  = r_held + 8'd1;
                    w_new.run_byte  = rce_pkg::RUN_CARRY;
                    w_new.run_count = r_pend;
                end
            end
            rce_pkg::OP_FIN_FLUSH: begin
                w_new_valid     = 1'b1;
                w_new.out_byte  = w_carry ? (r_held + 8'd1) : r_held;
                w_new.run_byte  = w_carry ? rce_pkg::RUN_CARRY : rce_pkg::RUN_NO_CARRY;
                w_new.run_count = r_pend;
            end
            rce_pkg::OP_FIN_CODE: begin
                w_new_valid    = 1'b1;
                w_new.out_byte = r_fin;
            end
            rce_pkg::OP_FIN_CB2: begin
                w_new_valid    = 1'b1;
                w_new.out_byte = r_bc[23:16];
            end
            rce_pkg::OP_FIN_CB1: begin
                w_new_valid    = 1'b1;
                w_new.out_byte = r_bc[15:8];
            end
            rce_pkg::OP_FIN_CB0: begin
                w_new_valid    = 1'b1;
                w_new.out_byte = r_bc[7:0];
            end
            default: begin
                w_new_valid = 1'b0;
            end
        endcase
    end

    assign w_push = (w_new_valid || (i_op == rce_pkg::OP_DONE)) && r_stg_valid;

    always_comb begin
        n_cmd       = r_cmd;
        n_cum       = r_cum;
        n_sf        = r_sf;
        n_lg        = r_lg;
        n_low       = r_low;
        n_width     = r_width;
        n_held      = r_held;
        n_pend      = r_pend;
        n_bc        = r_bc;
        n_ovf       = r_ovf;
        n_r         = r_r;
        n_t         = r_t;
        n_use_sub   = r_use_sub;
        n_fin       = r_fin;
        n_hdr       = r_hdr;
        n_fast      = r_fast;
        n_stg_valid = r_stg_valid;
        n_stg       = r_stg;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                rce_pkg::REG_HEADER_BYTE: n_hdr  = i_cfg_data;
                rce_pkg::REG_FAST_MODE:   n_fast = i_cfg_data[0];
                default:                  n_hdr  = r_hdr;
            endcase
        end

        unique case (i_op)
            rce_pkg::OP_LOAD: begin
                n_cmd = i_in_data.command;
                n_cum = i_in_data.cum_freq;
                n_sf  = i_in_data.sym_freq;
                n_lg  = (i_in_data.log_total > rce_pkg::LOG_LIMIT) ?
                        rce_pkg::LOG_LIMIT : i_in_data.log_total;
            end
            rce_pkg::OP_NORM: begin
                if (w_new_valid) begin
                    n_pend = '0;
                    n_held = r_low[30:23];
                end else if (r_pend < rce_pkg::PENDING_LIMIT) begin
                    n_pend = r_pend + 16'd1;
                end else begin
                    n_ovf = 1'b1;
                end
                n_width = {r_width[23:0], 8'h00};
                n_low   = {1'b0, r_low[22:0], 8'h00};
                n_bc    = r_bc + 24'd1;
            end
            rce_pkg::OP_SHIFT: begin
                n_r       = r_width >> r_lg;
                n_use_sub = !r_fast && ((w_sum >> r_lg) != 23'd0);
            end
            rce_pkg::OP_MUL_T: begin
                n_t = w_mul[31:0];
            end
            rce_pkg::OP_MUL_F: begin
                n_low   = r_low + r_t;
                n_width = r_use_sub ? (r_width - r_t) : w_mul[31:0];
            end
            rce_pkg::OP_FIN_CNT: begin
                n_bc = r_bc + rce_pkg::FINISH_BYTES;
            end
            rce_pkg::OP_FIN_FLUSH: begin
                n_pend = '0;
                n_fin  = w_fin[7:0];
            end
            rce_pkg::OP_DONE: begin
                if (r_cmd) begin
                    n_low   = '0;
                    n_width = rce_pkg::TOP_BIT;
                    n_held  = r_hdr;
                    n_pend  = '0;
                    n_bc    = '0;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_cmd = r_cmd;
            end
        endcase

        // A result waits in the staging register until it is known whether it closes the item.
        if (w_new_valid) begin
            if (r_stg_valid) begin
                n_out       = r_stg;
                n_out_valid = 1'b1;
            end
            n_stg       = w_new;
            n_stg_valid = 1'b1;
        end else if ((i_op == rce_pkg::OP_DONE) && r_stg_valid) begin
            n_out       = r_stg;
            n_out.last  = 1'b1;
            n_out_valid = 1'b1;
            n_stg_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low       <= '0;
            r_width     <= rce_pkg::TOP_BIT;
            r_held      <= '0;
            r_pend      <= '0;
            r_bc        <= '0;
            r_ovf       <= 1'b0;
            r_hdr       <= '0;
            r_fast      <= 1'b0;
            r_cmd       <= 1'b0;
            r_stg_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_low       <= n_low;
            r_width     <= n_width;
            r_held      <= n_held;
            r_pend      <= n_pend;
            r_bc        <= n_bc;
            r_ovf       <= n_ovf;
            r_hdr       <= n_hdr;
            r_fast      <= n_fast;
            r_cmd       <= n_cmd;
            r_stg_valid <= n_stg_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cum     <= n_cum;
        r_sf      <= n_sf;
        r_lg      <= n_lg;
        r_r       <= n_r;
        r_t       <= n_t;
        r_use_sub <= n_use_sub;
        r_fin     <= n_fin;
        r_stg     <= n_stg;
        r_out     <= n_out;
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out;
    assign o_status.need_norm = (r_width <= rce_pkg::BOTTOM_LEVEL);
    assign o_status.is_finish = r_cmd;
    assign o_status.out_free  = w_out_free;

    a_push_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (!r_out_valid || !i_out_stall))
        else $error("result pushed into an occupied output register");

    a_finish_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_op == rce_pkg::OP_DONE) && r_cmd) |=>
        ((r_width == rce_pkg::TOP_BIT) && (r_pend == 16'd0) && (r_bc == 24'd0)))
        else $error("finish did not return the coder to its initial state");

    a_norm_clears_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == rce_pkg::OP_NORM) |=> !r_low[31])
        else $error("renormalisation left the top bit of the low bound set");

    a_done_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == rce_pkg::OP_DONE) |=> !r_stg_valid)
        else $error("staged result left behind at the end of an item");

endmodule

// File: hdl/range_coder_encoder.sv
// Items are taken only in idle. Each takes k = 0..3 renormalisation steps; an encode item then
// shifts and runs MUL_T and MUL_F, a finish item flushes and sends its code byte and three count
// bytes. One shared 32 x 22 multiplier gives the low increment and, unless the width is taken by
// subtraction, the new width. Every renormalisation step, finish beat and closing step waits while
// the output register holds a stalled beat. Results pass a staging and an output register. Reset
// is synchronous, active low, restores the initial interval and clears both configuration registers.
module range_coder_encoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  rce_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output rce_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_we,
    input  logic [rce_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rce_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    rce_pkg::t_op        w_op;
    rce_pkg::t_dp_status w_status;

    rce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_op       (w_op),
        .o_in_stall (o_in_stall)
    );

    rce_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_status    (w_status)
    );

endmodule
